@@ rtl/core/ffha_pkg.sv @@
// Types, codes and constants shared by the first-fit heap allocator.
package ffha_pkg;

  localparam int unsigned HeapWordsDef  = 16384;
  localparam int unsigned ChunkBytesDef = 4096;
  localparam int unsigned MemWordsCap   = 16384;

  // Byte offsets and block sizes: the whole heap is at most 65536 bytes.
  localparam int unsigned OffW = 17;
  typedef logic [OffW-1:0] off_t;

  localparam off_t MinBlock   = 17'd16;
  localparam off_t PrologueBp = 17'd16;
  localparam off_t FirstBp    = 17'd24;

  typedef enum logic {
    CMD_ALLOC = 1'b0,
    CMD_FREE  = 1'b1
  } cmd_e;

  typedef enum logic [1:0] {
    RSP_OK      = 2'd0,
    RSP_ZERO    = 2'd1,
    RSP_OOM     = 2'd2,
    RSP_IGNORED = 2'd3
  } rsp_status_e;

  typedef enum logic [4:0] {
    FSM_INIT,
    FSM_IDLE,
    FSM_SRCH_RD,
    FSM_SRCH_CHK,
    FSM_GROW_CHK,
    FSM_GROW_WR,
    FSM_GROW_RDP,
    FSM_GROW_MRG,
    FSM_GROW_MWR,
    FSM_PLACE,
    FSM_FREE_RD,
    FSM_FREE_CHK,
    FSM_FREE_WR,
    FSM_FREE_RDP,
    FSM_FREE_RDN,
    FSM_FREE_MRG,
    FSM_FREE_MWR,
    FSM_DONE
  } fsm_e;

  typedef struct packed {
    logic        cmd;
    logic [15:0] req_bytes;
    logic [15:0] free_offset;
  } alloc_req_t;

  typedef struct packed {
    logic [15:0] payload_offset;
    logic [1:0]  status;
  } alloc_rsp_t;

  // Boundary tag word: block size with the allocated flag in bit 0.
  function automatic logic [31:0] tag_word(off_t size, logic used);
    tag_word = {15'd0, size[OffW-1:1], used};
  endfunction

  function automatic off_t tag_size(logic [31:0] w);
    tag_size = {w[OffW-1:3], 3'b000};
  endfunction

endpackage

@@ rtl/core/first_fit_heap_allocator.sv @@
// First-fit heap allocator with boundary tags over a single-port word memory.
//
//   channel  direction  payload       handshake
//   in       input      alloc_req_t   in_valid_i / in_ready_o
//   out      output     alloc_rsp_t   out_valid_o / out_ready_i
//
// An allocate is accepted, then reads and checks each block header it visits on the first-fit
// walk, grows the heap when no free block fits, writes the tags (and the remainder's tags when
// the block is split), and passes the beat to the output register. A free walks the blocks
// up to the target, then clears the flag and merges with free neighbours.
// The single memory port allows one access per cycle.
// After reset the block writes the initial heap tags (only prologue and epilogue without a chunk).
// A finished beat waits in the output register while the next beat is taken.
module first_fit_heap_allocator #(
  parameter int unsigned HEAP_WORDS  = ffha_pkg::HeapWordsDef,
  parameter int unsigned CHUNK_BYTES = ffha_pkg::ChunkBytesDef
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  ffha_pkg::alloc_req_t in_beat_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output ffha_pkg::alloc_rsp_t out_beat_o
);
  import ffha_pkg::*;

  localparam int unsigned MemWords   = (HEAP_WORDS > MemWordsCap) ? MemWordsCap : HEAP_WORDS;
  localparam int unsigned Aw         = $clog2(MemWords);
  localparam int unsigned LimitBytes = MemWords * 4;
  localparam int unsigned ChunkW     = CHUNK_BYTES / 4;
  localparam int unsigned ChunkSz    = (ChunkW + (ChunkW % 2)) * 4;
  localparam bit          InitFits   = (24 + ChunkSz) <= LimitBytes;
  localparam int unsigned BrkInit    = InitFits ? (24 + ChunkSz) : 24;
  localparam off_t        LimitO     = OffW'(LimitBytes);
  localparam off_t        ChunkSzO   = OffW'(ChunkSz);
  localparam off_t        ChunkBytesO = OffW'(CHUNK_BYTES);
  localparam off_t        BrkInitO   = OffW'(BrkInit);

  fsm_e        state_q, state_d;
  logic [2:0]  step_q, step_d;
  off_t        bp_q, bp_d;
  off_t        size_q, size_d;
  off_t        asize_q, asize_d;
  off_t        brk_q, brk_d;
  logic [15:0] foff_q, foff_d;
  logic        p_used_q, p_used_d;
  off_t        p_size_q, p_size_d;
  alloc_rsp_t  rsp_q, rsp_d;
  logic        out_valid_q, out_valid_d;
  alloc_rsp_t  out_q, out_d;

  logic        mem_en, mem_we;
  off_t        mem_off;
  logic [31:0] mem_wdata;
  logic [31:0] rdata_q;
  logic [31:0] mem_q [MemWords];

  off_t        rd_size;
  logic        rd_used;
  off_t        gsize;
  logic        split;
  logic [OffW:0] grow_end;

  assign rd_size  = tag_size(rdata_q);
  assign rd_used  = rdata_q[0];
  assign gsize    = (asize_q > ChunkBytesO) ? asize_q : ChunkSzO;
  assign grow_end = {1'b0, brk_q} + {1'b0, gsize};
  assign split    = (size_q - asize_q) >= MinBlock;

  // Next state and datapath registers.
  always_comb begin
    state_d     = state_q;
    step_d      = step_q;
    bp_d        = bp_q;
    size_d      = size_q;
    asize_d     = asize_q;
    brk_d       = brk_q;
    foff_d      = foff_q;
    p_used_d    = p_used_q;
    p_size_d    = p_size_q;
    rsp_d       = rsp_q;
    out_valid_d = out_valid_q & ~out_ready_i;
    out_d       = out_q;
    unique case (state_q)
      FSM_INIT: begin
        if (step_q == (InitFits ? 3'd4 : 3'd2)) begin
          state_d = FSM_IDLE;
          step_d  = '0;
        end else begin
          step_d = step_q + 3'd1;
        end
      end
      FSM_IDLE: begin
        if (in_valid_i) begin
          rsp_d = '{payload_offset: 16'd0, status: RSP_OK};
          if (in_beat_i.cmd == CMD_ALLOC) begin
            if (in_beat_i.req_bytes == 16'd0) begin
              rsp_d.status = RSP_ZERO;
              state_d      = FSM_DONE;
            end else begin
              asize_d = (in_beat_i.req_bytes <= 16'd8) ? MinBlock :
                        ((OffW'(in_beat_i.req_bytes) + 17'd15) & ~17'd7);
              bp_d    = PrologueBp;
              state_d = FSM_SRCH_RD;
            end
          end else begin
            if (in_beat_i.free_offset == 16'd0) begin
              rsp_d.status = RSP_IGNORED;
              state_d      = FSM_DONE;
            end else begin
              foff_d  = in_beat_i.free_offset;
              bp_d    = FirstBp;
              state_d = FSM_FREE_RD;
            end
          end
        end
      end
      FSM_SRCH_RD: state_d = FSM_SRCH_CHK;
      FSM_SRCH_CHK: begin
        if (rd_size == '0) begin
          state_d = FSM_GROW_CHK;
        end else if (!rd_used && (asize_q <= rd_size)) begin
          size_d  = rd_size;
          step_d  = '0;
          state_d = FSM_PLACE;
        end else begin
          bp_d    = bp_q + rd_size;
          state_d = FSM_SRCH_RD;
        end
      end
      FSM_GROW_CHK: begin
        if (grow_end > {1'b0, LimitO}) begin
          rsp_d.status = RSP_OOM;
          state_d      = FSM_DONE;
        end else begin
          bp_d    = brk_q;
          size_d  = gsize;
          step_d  = '0;
          state_d = FSM_GROW_WR;
        end
      end
      FSM_GROW_WR: begin
        if (step_q == 3'd2) begin
          brk_d   = bp_q + size_q;
          step_d  = '0;
          state_d = FSM_GROW_RDP;
        end else begin
          step_d = step_q + 3'd1;
        end
      end
      FSM_GROW_RDP: state_d = FSM_GROW_MRG;
      FSM_GROW_MRG: begin
        step_d = '0;
        if (!rd_used) begin
          bp_d    = bp_q - rd_size;
          size_d  = size_q + rd_size;
          state_d = FSM_GROW_MWR;
        end else begin
          state_d = FSM_PLACE;
        end
      end
      FSM_GROW_MWR: begin
        if (step_q == 3'd1) begin
          step_d  = '0;
          state_d = FSM_PLACE;
        end else begin
          step_d = step_q + 3'd1;
        end
      end
      FSM_PLACE: begin
        if (step_q == (split ? 3'd3 : 3'd1)) begin
          rsp_d.payload_offset = bp_q[15:0];
          step_d  = '0;
          state_d = FSM_DONE;
        end else begin
          step_d = step_q + 3'd1;
        end
      end
      FSM_FREE_RD: begin
        if (bp_q > {1'b0, foff_q}) begin
          rsp_d.status = RSP_IGNORED;
          state_d      = FSM_DONE;
        end else begin
          state_d = FSM_FREE_CHK;
        end
      end
      FSM_FREE_CHK: begin
        if (rd_size == '0) begin
          rsp_d.status = RSP_IGNORED;
          state_d      = FSM_DONE;
        end else if (bp_q == {1'b0, foff_q}) begin
          if (rd_used) begin
            size_d  = rd_size;
            step_d  = '0;
            state_d = FSM_FREE_WR;
          end else begin
            rsp_d.status = RSP_IGNORED;
            state_d      = FSM_DONE;
          end
        end else begin
          bp_d    = bp_q + rd_size;
          state_d = FSM_FREE_RD;
        end
      end
      FSM_FREE_WR: begin
        if (step_q == 3'd1) begin
          step_d  = '0;
          state_d = FSM_FREE_RDP;
        end else begin
          step_d = step_q + 3'd1;
        end
      end
      FSM_FREE_RDP: state_d = FSM_FREE_RDN;
      FSM_FREE_RDN: begin
        p_used_d = rd_used;
        p_size_d = rd_size;
        state_d  = FSM_FREE_MRG;
      end
      FSM_FREE_MRG: begin
        if (p_used_q && rd_used) begin
          state_d = FSM_DONE;
        end else begin
          size_d  = size_q + (rd_used ? '0 : rd_size) + (p_used_q ? '0 : p_size_q);
          bp_d    = p_used_q ? bp_q : (bp_q - p_size_q);
          step_d  = '0;
          state_d = FSM_FREE_MWR;
        end
      end
      FSM_FREE_MWR: begin
        if (step_q == 3'd1) begin
          step_d  = '0;
          state_d = FSM_DONE;
        end else begin
          step_d = step_q + 3'd1;
        end
      end
      FSM_DONE: begin
        if (!out_valid_q || out_ready_i) begin
          out_valid_d = 1'b1;
          out_d       = rsp_q;
          state_d     = FSM_IDLE;
        end
      end
      default: state_d = FSM_IDLE;
    endcase
  end

  // Memory port control.
  always_comb begin
    mem_en    = 1'b0;
    mem_we    = 1'b0;
    mem_off   = '0;
    mem_wdata = '0;
    unique case (state_q)
      FSM_INIT: begin
        mem_en = 1'b1;
        mem_we = 1'b1;
        unique case (step_q)
          3'd0: begin mem_off = 17'd12; mem_wdata = tag_word(17'd8, 1'b1); end
          3'd1: begin mem_off = 17'd16; mem_wdata = tag_word(17'd8, 1'b1); end
          3'd2: begin
            mem_off   = 17'd20;
            mem_wdata = InitFits ? tag_word(ChunkSzO, 1'b0) : tag_word('0, 1'b1);
          end
          3'd3: begin mem_off = BrkInitO - 17'd8; mem_wdata = tag_word(ChunkSzO, 1'b0); end
          default: begin mem_off = BrkInitO - 17'd4; mem_wdata = tag_word('0, 1'b1); end
        endcase
      end
      FSM_SRCH_RD, FSM_FREE_RD: begin
        mem_en  = 1'b1;
        mem_off = bp_q - 17'd4;
      end
      FSM_GROW_RDP, FSM_FREE_RDP: begin
        mem_en  = 1'b1;
        mem_off = bp_q - 17'd8;
      end
      FSM_FREE_RDN: begin
        mem_en  = 1'b1;
        mem_off = bp_q + size_q - 17'd4;
      end
      FSM_GROW_WR: begin
        mem_en = 1'b1;
        mem_we = 1'b1;
        unique case (step_q)
          3'd0: begin mem_off = bp_q - 17'd4; mem_wdata = tag_word(size_q, 1'b0); end
          3'd1: begin mem_off = bp_q + size_q - 17'd8; mem_wdata = tag_word(size_q, 1'b0); end
          default: begin mem_off = bp_q + size_q - 17'd4; mem_wdata = tag_word('0, 1'b1); end
        endcase
      end
      FSM_GROW_MWR, FSM_FREE_MWR, FSM_FREE_WR: begin
        mem_en    = 1'b1;
        mem_we    = 1'b1;
        mem_wdata = tag_word(size_q, 1'b0);
        mem_off   = (step_q == 3'd0) ? (bp_q - 17'd4) : (bp_q + size_q - 17'd8);
      end
      FSM_PLACE: begin
        mem_en = 1'b1;
        mem_we = 1'b1;
        if (split) begin
          unique case (step_q)
            3'd0: begin mem_off = bp_q - 17'd4; mem_wdata = tag_word(asize_q, 1'b1); end
            3'd1: begin mem_off = bp_q + asize_q - 17'd8; mem_wdata = tag_word(asize_q, 1'b1); end
            3'd2: begin
              mem_off   = bp_q + asize_q - 17'd4;
              mem_wdata = tag_word(size_q - asize_q, 1'b0);
            end
            default: begin
              mem_off   = bp_q + size_q - 17'd8;
              mem_wdata = tag_word(size_q - asize_q, 1'b0);
            end
          endcase
        end else begin
          mem_wdata = tag_word(size_q, 1'b1);
          mem_off   = (step_q == 3'd0) ? (bp_q - 17'd4) : (bp_q + size_q - 17'd8);
        end
      end
      default: begin
        mem_en = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (mem_en && mem_we) begin
      mem_q[mem_off[Aw+1:2]] <= mem_wdata;
    end
    if (mem_en && !mem_we) begin
      rdata_q <= mem_q[mem_off[Aw+1:2]];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= FSM_INIT;
      step_q      <= '0;
      brk_q       <= BrkInitO;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      step_q      <= step_d;
      brk_q       <= brk_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    bp_q     <= bp_d;
    size_q   <= size_d;
    asize_q  <= asize_d;
    foff_q   <= foff_d;
    p_used_q <= p_used_d;
    p_size_q <= p_size_d;
    rsp_q    <= rsp_d;
    out_q    <= out_d;
  end

  assign in_ready_o  = (state_q == FSM_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_beat_o  = out_q;

  // The break always sits on an eight-byte boundary inside the memory.
  a_brk_aligned : assert property (@(posedge clk_i) disable iff (!rst_ni)
    brk_q[2:0] == 3'd0)
    else $error("heap break is not eight-byte aligned");

  a_brk_limit : assert property (@(posedge clk_i) disable iff (!rst_ni)
    brk_q <= LimitO)
    else $error("heap break beyond the end of memory");

  a_payload_ok : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_beat_o.payload_offset != 16'd0) |-> out_beat_o.status == RSP_OK)
    else $error("payload offset returned with a failing status");

  a_idle_no_write : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == FSM_IDLE || state_q == FSM_DONE) |-> !mem_en)
    else $error("memory accessed while no command is in progress");

  a_done_to_idle : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == FSM_DONE && (!out_valid_q || out_ready_i)) |=> out_valid_q)
    else $error("finished beat not presented at the output");

endmodule
